[rtl/core/usage_pattern_tokenizer_assert.svh]
// Assertion macros shared by the tokenizer modules.
// Each expects clk and rst_n in scope.
`ifndef USAGE_PATTERN_TOKENIZER_ASSERT_SVH
`define USAGE_PATTERN_TOKENIZER_ASSERT_SVH

// Same-cycle implication.
`define UPT_ASSERT_IMP(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("upt: check failed");

// Next-cycle implication.
`define UPT_ASSERT_NXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("upt: check failed");

`endif

[rtl/core/upt_pkg.sv]
package upt_pkg;

  localparam int TOK_W = 16;
  localparam int MAX_TOK = 3;

  typedef enum logic [2:0] {
    KIND_WORD,
    KIND_LPAREN,
    KIND_RPAREN,
    KIND_LSQUARE,
    KIND_RSQUARE,
    KIND_BAR,
    KIND_ELLIPSIS,
    KIND_END
  } kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct packed {
    kind_t            kind;
    logic [TOK_W-1:0] start;
    logic [TOK_W-1:0] length;
    logic             unclosed;
    logic [TOK_W-1:0] obpos;
    logic             too_long;
    logic             final_res;
  } tok_t;

  typedef struct packed {
    tok_t [MAX_TOK-1:0] tok;
    logic [1:0]         cnt;
  } tok_set_t;

endpackage

[rtl/core/upt_in_reg.sv]
module upt_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  upt_pkg::item_t in_item,
  output logic          valid,
  input  logic          take,
  output upt_pkg::item_t item
);
  import upt_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;

  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_ready) begin
      valid_nxt = in_valid;
      item_nxt  = in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

[rtl/core/upt_core.sv]
`include "usage_pattern_tokenizer_assert.svh"

module upt_core #(
  parameter int POS_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  upt_pkg::item_t    item,
  output upt_pkg::tok_set_t set
);
  import upt_pkg::*;

  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_BAR     = 8'h7C;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  logic                in_angle_r, in_angle_nxt;
  logic                word_open_r, word_open_nxt;
  logic [POS_BITS-1:0] word_begin_r, word_begin_nxt;
  logic [POS_BITS-1:0] angle_begin_r, angle_begin_nxt;
  logic [1:0]          dots_pending_r, dots_pending_nxt;
  logic [POS_BITS-1:0] first_dot_pos_r, first_dot_pos_nxt;
  logic [POS_BITS-1:0] char_pos_r, char_pos_nxt;
  logic                pos_overflow_r, pos_overflow_nxt;

  function automatic logic [TOK_W-1:0] to_out(input logic [POS_BITS-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[TOK_W-1:0];
  endfunction

  function automatic logic [TOK_W-1:0] word_len(input logic [POS_BITS-1:0] e,
                                                input logic [POS_BITS-1:0] b);
    logic [POS_BITS-1:0] d;
    d = (e >= b) ? e - b : '0;
    return to_out(d);
  endfunction

  tok_t [MAX_TOK-1:0]  res;
  logic [1:0]          n;
  logic                ia, wo, ov, is_punct, is_space;
  logic [1:0]          dp;
  logic [POS_BITS-1:0] wb, ab, fd, pos, cp;
  kind_t               pk;

  always_comb begin
    res      = '0;
    n        = 2'd0;
    ia       = in_angle_r;
    wo       = word_open_r;
    dp       = dots_pending_r;
    wb       = word_begin_r;
    ab       = angle_begin_r;
    fd       = first_dot_pos_r;
    pos      = char_pos_r;
    ov       = pos_overflow_r || (pos == POS_MAX);
    cp       = (pos == POS_MAX) ? POS_MAX : pos + 1'b1;
    is_punct = 1'b1;
    pk       = KIND_WORD;
    case (item.ch)
      CH_LPAREN:  pk = KIND_LPAREN;
      CH_RPAREN:  pk = KIND_RPAREN;
      CH_LSQUARE: pk = KIND_LSQUARE;
      CH_RSQUARE: pk = KIND_RSQUARE;
      CH_BAR:     pk = KIND_BAR;
      default:    is_punct = 1'b0;
    endcase
    is_space = (item.ch == CH_SPACE) || (item.ch == CH_TAB) || (item.ch == CH_NL);

    if (ia) begin
      if (item.ch == CH_GT) begin
        ia = 1'b0;
      end
    end else if (item.ch == CH_DOT) begin
      if (dp == 2'd2) begin
        if (wo) begin
          res[n].kind   = KIND_WORD;
          res[n].start  = to_out(wb);
          res[n].length = word_len(fd, wb);
          n  = n + 2'd1;
          wo = 1'b0;
        end
        res[n].kind   = KIND_ELLIPSIS;
        res[n].start  = to_out(fd);
        res[n].length = TOK_W'(3);
        n  = n + 2'd1;
        dp = 2'd0;
      end else begin
        if (dp == 2'd0) begin
          fd = pos;
        end
        dp = dp + 2'd1;
      end
    end else begin
      if (dp != 2'd0) begin
        if (!wo) begin
          wo = 1'b1;
          wb = fd;
        end
        dp = 2'd0;
      end
      if (is_punct || is_space) begin
        if (wo) begin
          res[n].kind   = KIND_WORD;
          res[n].start  = to_out(wb);
          res[n].length = word_len(pos, wb);
          n  = n + 2'd1;
          wo = 1'b0;
        end
        if (is_punct) begin
          res[n].kind   = pk;
          res[n].start  = to_out(pos);
          res[n].length = TOK_W'(1);
          n = n + 2'd1;
        end
      end else begin
        if (!wo) begin
          wo = 1'b1;
          wb = pos;
        end
        if (item.ch == CH_LT) begin
          ia = 1'b1;
          ab = pos;
        end
      end
    end

    if (item.last) begin
      if (dp != 2'd0) begin
        if (!wo) begin
          wo = 1'b1;
          wb = fd;
        end
      end
      if (wo) begin
        res[n].kind   = KIND_WORD;
        res[n].start  = to_out(wb);
        res[n].length = word_len(cp, wb);
        n = n + 2'd1;
      end
      res[n].kind      = KIND_END;
      res[n].start     = to_out(cp);
      res[n].unclosed  = ia;
      res[n].obpos     = ia ? to_out(ab) : '0;
      res[n].too_long  = ov;
      res[n].final_res = 1'b1;
      n = n + 2'd1;
      ia = 1'b0;
      wo = 1'b0;
      dp = 2'd0;
      wb = '0;
      ab = '0;
      fd = '0;
      cp = '0;
      ov = 1'b0;
    end

    in_angle_nxt      = in_angle_r;
    word_open_nxt     = word_open_r;
    word_begin_nxt    = word_begin_r;
    angle_begin_nxt   = angle_begin_r;
    dots_pending_nxt  = dots_pending_r;
    first_dot_pos_nxt = first_dot_pos_r;
    char_pos_nxt      = char_pos_r;
    pos_overflow_nxt  = pos_overflow_r;
    if (fire) begin
      in_angle_nxt      = ia;
      word_open_nxt     = wo;
      word_begin_nxt    = wb;
      angle_begin_nxt   = ab;
      dots_pending_nxt  = dp;
      first_dot_pos_nxt = fd;
      char_pos_nxt      = cp;
      pos_overflow_nxt  = ov;
    end

    set.tok = res;
    set.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_angle_r      <= 1'b0;
      word_open_r     <= 1'b0;
      word_begin_r    <= '0;
      angle_begin_r   <= '0;
      dots_pending_r  <= 2'd0;
      first_dot_pos_r <= '0;
      char_pos_r      <= '0;
      pos_overflow_r  <= 1'b0;
    end else begin
      in_angle_r      <= in_angle_nxt;
      word_open_r     <= word_open_nxt;
      word_begin_r    <= word_begin_nxt;
      angle_begin_r   <= angle_begin_nxt;
      dots_pending_r  <= dots_pending_nxt;
      first_dot_pos_r <= first_dot_pos_nxt;
      char_pos_r      <= char_pos_nxt;
      pos_overflow_r  <= pos_overflow_nxt;
    end
  end

  `UPT_ASSERT_IMP(a_dots_max, 1'b1, dots_pending_r != 2'd3)
  `UPT_ASSERT_NXT(a_last_clears, fire && item.last,
                  !in_angle_r && !word_open_r && dots_pending_r == 2'd0 && char_pos_r == '0)
  `UPT_ASSERT_IMP(a_end_present, fire && item.last, set.cnt != 2'd0)

endmodule

[rtl/core/upt_res_buf.sv]
`include "usage_pattern_tokenizer_assert.svh"

module upt_res_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  upt_pkg::tok_set_t set,
  output logic              load_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output upt_pkg::tok_t     out_tok
);
  import upt_pkg::*;

  tok_t [MAX_TOK-1:0] slot_r, slot_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign load_ok   = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign out_tok   = slot_r[0];

  always_comb begin
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      slot_nxt = set.tok;
      cnt_nxt  = set.cnt;
    end else if (pop) begin
      slot_nxt[0] = slot_r[1];
      slot_nxt[1] = slot_r[2];
      cnt_nxt     = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  `UPT_ASSERT_IMP(a_load_when_free, load, cnt_r == 2'd0 || (cnt_r == 2'd1 && pop))
  `UPT_ASSERT_NXT(a_load_count, load, cnt_r == $past(set.cnt))
  `UPT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_tok))

endmodule

[rtl/core/usage_pattern_tokenizer.sv]
// Usage-pattern tokenizer: takes one pattern character per item (tlast on the
// final one) and returns word, bracket, bar and ellipsis tokens with start offset
// and length, then an end marker (tlast) carrying the pattern length, an open
// angle bracket flag with its offset and an overflow flag. Items pass an input
// register and a combinational tokenizing step into a three-entry result buffer.
// One item is taken per cycle while each yields at most one token and out_tready
// is held high; an item yielding two or three tokens (a word closed by a bracket,
// bar or ellipsis, or the end marker) holds the input until the buffer is down to
// its last token, as the single output port drains the result buffer one token per
// cycle while out_tready is high.
module usage_pattern_tokenizer #(
  parameter int POS_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [15:0] token_start, [31:16] token_length,
                                  // [32] unclosed_bracket, [48:33] open_bracket_pos,
                                  // [49] too_long, [55:50] zero
  output logic [2:0]  out_tuser,  // [2:0] token_kind
  output logic        out_tlast
);
  import upt_pkg::*;

  item_t    in_item, item;
  logic     item_valid, load_ok, fire;
  tok_set_t set;
  tok_t     tok;

  assign in_item.ch   = in_tdata;
  assign in_item.last = in_tlast;
  assign fire         = item_valid && load_ok;

  upt_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .valid    (item_valid),
    .take     (load_ok),
    .item     (item)
  );

  upt_core #(
    .POS_BITS (POS_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .set   (set)
  );

  upt_res_buf u_res_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .set       (set),
    .load_ok   (load_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (tok)
  );

  assign out_tdata = {6'b0, tok.too_long, tok.obpos, tok.unclosed, tok.length, tok.start};
  assign out_tuser = tok.kind;
  assign out_tlast = tok.final_res;

endmodule

[test/usage_pattern_tokenizer_tb.sv]
`timescale 1ns / 100ps

module usage_pattern_tokenizer_tb;
  import upt_pkg::*;

  localparam logic [15:0] POS_TOP = 16'hFFFF;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] ch
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // [15:0] start, [31:16] length, [32] unclosed,
                           // [48:33] open bracket pos, [49] too_long
  logic [2:0]  out_tuser;  // [2:0] token kind
  logic        out_tlast;

  bit quiet;
  int sent;
  logic [7:0] pattern[$];
  string puncts = "()[]|";
  string gaps = " \t\n";

  class token_board;
    tok_t expected_tokens[$];
    int errors;
    bit in_angle;
    bit word_open;
    bit overflow;
    int dots;
    logic [15:0] word_begin;
    logic [15:0] angle_begin;
    logic [15:0] first_dot;
    logic [15:0] char_pos;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      in_angle = 0;
      word_open = 0;
      overflow = 0;
      dots = 0;
      word_begin = '0;
      angle_begin = '0;
      first_dot = '0;
      char_pos = '0;
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction

    function void add(kind_t k, logic [15:0] s, logic [15:0] l);
      tok_t t;
      t = '0;
      t.kind = k;
      t.start = s;
      t.length = l;
      expected_tokens = {expected_tokens, t};
    endfunction

    function void close_word(logic [15:0] stop);
      if (word_open) begin
        add(KIND_WORD, word_begin, (stop >= word_begin) ? stop - word_begin : 16'd0);
        word_open = 0;
      end
    endfunction

    // pending dots that never made an ellipsis become word text
    function void settle_dots();
      if (dots != 0) begin
        if (!word_open) begin
          word_open = 1;
          word_begin = first_dot;
        end
        dots = 0;
      end
    endfunction

    function void note_char(logic [7:0] c, logic is_last);
      logic [15:0] p;
      kind_t pk;
      int n;
      p = char_pos;
      if (p == POS_TOP) overflow = 1;
      if (in_angle) begin
        if (c == ">") in_angle = 0;
      end else if (c == ".") begin
        if (dots == 2) begin
          close_word(first_dot);
          add(KIND_ELLIPSIS, first_dot, 16'd3);
          dots = 0;
        end else begin
          if (dots == 0) first_dot = p;
          dots++;
        end
      end else begin
        case (c)
          "(": pk = KIND_LPAREN;
          ")": pk = KIND_RPAREN;
          "[": pk = KIND_LSQUARE;
          "]": pk = KIND_RSQUARE;
          "|": pk = KIND_BAR;
          default: pk = KIND_WORD;
        endcase
        settle_dots();
        if (pk != KIND_WORD) begin
          close_word(p);
          add(pk, p, 16'd1);
        end else if (c == " " || c == "\t" || c == "\n") begin
          close_word(p);
        end else begin
          if (!word_open) begin
            word_open = 1;
            word_begin = p;
          end
          if (c == "<") begin
            in_angle = 1;
            angle_begin = p;
          end
        end
      end
      char_pos = (p != POS_TOP) ? p + 16'd1 : p;
      if (is_last) begin
        settle_dots();
        close_word(char_pos);
        add(KIND_END, char_pos, 16'd0);
        n = expected_tokens.size() - 1;
        expected_tokens[n].unclosed = in_angle;
        expected_tokens[n].obpos = in_angle ? angle_begin : 16'd0;
        expected_tokens[n].too_long = overflow;
        expected_tokens[n].final_res = 1'b1;
        clear();
      end
    endfunction

    function void check_token(tok_t got);
      tok_t want;
      if (expected_tokens.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected token: kind %0d start %0d len %0d", got.kind, got.start,
                   got.length);
        return;
      end
      want = expected_tokens.pop_front();
      if (got.kind !== want.kind || got.start !== want.start || got.length !== want.length ||
          got.unclosed !== want.unclosed || got.obpos !== want.obpos ||
          got.too_long !== want.too_long || got.final_res !== want.final_res) begin
        errors++;
        if (errors <= 10) begin
          $display("token mismatch: exp kind %0d start %0d len %0d unc %0d obp %0d tl %0d fin %0d",
                   want.kind, want.start, want.length, want.unclosed, want.obpos,
                   want.too_long, want.final_res);
          $display("                got kind %0d start %0d len %0d unc %0d obp %0d tl %0d fin %0d",
                   got.kind, got.start, got.length, got.unclosed, got.obpos,
                   got.too_long, got.final_res);
        end
      end
    endfunction
  endclass

  token_board board = new();

  usage_pattern_tokenizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.note_char(in_tdata, in_tlast);
  end

  always @(posedge clk) begin
    tok_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '0;
      got.kind = kind_t'(out_tuser);
      got.start = out_tdata[15:0];
      got.length = out_tdata[31:16];
      got.unclosed = out_tdata[32];
      got.obpos = out_tdata[48:33];
      got.too_long = out_tdata[49];
      got.final_res = out_tlast;
      board.check_token(got);
    end
  end

  // receiver stalls
  initial begin
    out_tready <= 1'b0;
    repeat (3) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  task automatic send_char(input logic [7:0] c, input logic is_last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_pattern();
    for (int i = 0; i < pattern.size(); i++) send_char(pattern[i], i == pattern.size() - 1);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int random_start;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_string("[ab...]");
    send_string("(<a b>)");
    send_string("....");
    send_string(" \n..");
    send_char("|", 1'b0);
    send_char(8'h00, 1'b0);
    send_char("<", 1'b0);
    send_char(8'hFF, 1'b1);
    drain();

    random_start = sent;
    while (sent < random_start + 125) begin
      quiet = (sent >= random_start + 100);
      pattern.delete();
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 12)) pattern = {pattern, 8'($urandom_range(0, 255))};
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 7))
            0: repeat ($urandom_range(1, 6))
                 pattern = {pattern, 8'("a" + $urandom_range(0, 25))};
            1: begin
              if ($urandom_range(0, 1)) pattern = {pattern, 8'("x")};
              pattern = {pattern, 8'("<")};
              repeat ($urandom_range(0, 5))
                pattern = {pattern, ($urandom_range(0, 3) == 0) ? 8'(" ") :
                                    8'("a" + $urandom_range(0, 25))};
              if ($urandom_range(0, 5) != 0) pattern = {pattern, 8'(">")};
            end
            2: pattern = {pattern, 8'(puncts[$urandom_range(0, 4)])};
            3: pattern = {pattern, 8'(gaps[$urandom_range(0, 2)])};
            4: repeat ($urandom_range(1, 7)) pattern = {pattern, 8'(".")};
            5: pattern = {pattern, 8'($urandom_range(0, 255))};
            6: begin
              pattern = {pattern, 8'("a" + $urandom_range(0, 25))};
              pattern = {pattern, 8'(".")};
              pattern = {pattern, 8'("b")};
            end
            default: begin
              pattern = {pattern, 8'("<")};
              pattern = {pattern, 8'($urandom_range(0, 255))};
            end
          endcase
        end
      end
      send_pattern();
    end

    drain();
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
